>>> src/rmvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmvg_pkg
// Shared types, constants and helpers of the ring mesh vertex generator.
// ----------------------------------------------------------------------------
package rmvg_pkg;

   // Limits on the column and row counts
   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_BASE_RADIUS  = 3'd0;
   localparam logic [2:0] REG_RADIUS_STEP  = 3'd1;
   localparam logic [2:0] REG_HEIGHT_STEP  = 3'd2;
   localparam logic [2:0] REG_COLUMN_COUNT = 3'd3;
   localparam logic [2:0] REG_ROW_COUNT    = 3'd4;

   // Fixed point constants
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [17:0]        U_FULL      = 18'd131072;
   localparam logic [16:0]        V_FULL      = 17'd65536;

   // Pipeline layout
   localparam int MOD_FIRST    = 1;
   localparam int MOD_STEPS    = 9;
   localparam int FRAC_FIRST   = MOD_FIRST + MOD_STEPS;
   localparam int TH_BITS      = 33;
   localparam int U_BITS       = 18;
   localparam int V_BITS       = 17;
   localparam int FIN_STG      = FRAC_FIRST + TH_BITS;
   localparam int CORDIC_FIRST = FIN_STG + 1;
   localparam int CORDIC_STEPS = 30;
   localparam int QUAD_STG     = CORDIC_FIRST + CORDIC_STEPS;
   localparam int MULT_STG     = QUAD_STG + 1;
   localparam int SUM_STG      = MULT_STG + 1;
   localparam int OUT_STG      = SUM_STG + 1;
   localparam int NUM_STG      = OUT_STG + 1;

   typedef struct packed {
      logic [8:0] row_index;
      logic [8:0] column_index;
   } req_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [17:0]        tex_u;
      logic [16:0]        tex_v;
   } rsp_type;

   // Per-stage working set of one vertex
   typedef struct packed {
      logic [8:0]         row;
      logic [8:0]         col;
      logic [8:0]         rem;
      logic [8:0]         th_r;
      logic [32:0]        th_q;
      logic [8:0]         u_r;
      logic [17:0]        u_q;
      logic [8:0]         v_r;
      logic [16:0]        v_q;
      logic signed [33:0] radius;
      logic signed [23:0] pos_y;
      logic [17:0]        tex_u;
      logic [16:0]        tex_v;
      logic signed [32:0] cx;
      logic signed [32:0] cy;
      logic signed [32:0] cz;
      logic [1:0]         quad;
      logic signed [32:0] ax;
      logic signed [32:0] az;
      logic signed [50:0] pxl;
      logic signed [49:0] pxh;
      logic signed [50:0] pzl;
      logic signed [49:0] pzh;
      logic signed [67:0] sx;
      logic signed [67:0] sz;
      logic signed [23:0] ox;
      logic signed [23:0] oz;
   } pipe_type;

   // Arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [31:0] atan_val(input int i);
      logic [31:0] a;
      case (i)
         0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
         3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
         6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
         9: a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
        12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9;
        15: a = 32'h0000517C; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
        18: a = 32'h00000A2F; 19: a = 32'h00000517; 20: a = 32'h0000028B;
        21: a = 32'h00000145; 22: a = 32'h000000A2; 23: a = 32'h00000051;
        24: a = 32'h00000028; 25: a = 32'h00000014; 26: a = 32'h0000000A;
        27: a = 32'h00000005; 28: a = 32'h00000002; 29: a = 32'h00000001;
        default: a = 32'h0;
      endcase
      return a;
   endfunction

   // Clamp a wide signed value to 24 bits
   function automatic logic signed [23:0] sat24(input logic signed [67:0] v);
      logic signed [23:0] r;
      if (v > 68'sd8388607) begin
         r = 24'sd8388607;
      end else if (v < -68'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

>>> src/ring_mesh_vertex_generator_unit.sv
`timescale 1ns / 1ps
// Throughput: one vertex per cycle unless the result stalls; 78 register stages
// (entry, 9 modulo steps, 33 phase and UV division steps, rounding, 30 CORDIC
// rotations, quadrant, multiply, sum, round) each take one item.
// A stalled result freezes the whole pipeline until it is transferred.
// Reset: synchronous, clears all stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// ring_mesh_vertex_generator_unit
// Maps a ring mesh row and column to a fixed point 3-D point and texture UV.
// ----------------------------------------------------------------------------
module ring_mesh_vertex_generator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rmvg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rmvg_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import rmvg_pkg::*;

   logic [22:0]        base_radius_ff;
   logic signed [23:0] radius_step_ff;
   logic signed [23:0] height_step_ff;
   logic [8:0]         column_count_ff;
   logic [8:0]         row_count_ff;
   logic [8:0]         cols_eff;
   logic [8:0]         rows_eff;
   logic [2:0]         reg_idx;
   logic               wr_en;
   logic               adv;

   pipe_type             pipe_ff [NUM_STG];
   pipe_type             pipe_in [NUM_STG];
   logic [NUM_STG-1:0]   vld_ff;

   // Configuration port
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_radius_ff  <= '0;
         radius_step_ff  <= '0;
         height_step_ff  <= '0;
         column_count_ff <= 9'd1;
         row_count_ff    <= 9'd1;
      end else if (wr_en) begin
         case (reg_idx)
            REG_BASE_RADIUS:  base_radius_ff  <= pwdata[22:0];
            REG_RADIUS_STEP:  radius_step_ff  <= pwdata[23:0];
            REG_HEIGHT_STEP:  height_step_ff  <= pwdata[23:0];
            REG_COLUMN_COUNT: column_count_ff <= pwdata[8:0];
            REG_ROW_COUNT:    row_count_ff    <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_BASE_RADIUS:  prdata = {9'd0, base_radius_ff};
         REG_RADIUS_STEP:  prdata = {8'd0, radius_step_ff};
         REG_HEIGHT_STEP:  prdata = {8'd0, height_step_ff};
         REG_COLUMN_COUNT: prdata = {23'd0, column_count_ff};
         REG_ROW_COUNT:    prdata = {23'd0, row_count_ff};
         default:          prdata = '0;
      endcase
   end

   // Clamp counts to the supported maximum
   assign cols_eff = (column_count_ff > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : column_count_ff;
   assign rows_eff = (row_count_ff > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : row_count_ff;

   // Hold every stage while the result waits
   assign adv       = !(vld_ff[OUT_STG] && rsp_stall);
   assign req_stall = !adv;

   for (genvar j = 0; j < NUM_STG; j++) begin : g_stg
      if (j == 0) begin : g_entry
         logic signed [33:0] r_prod;
         logic signed [33:0] h_prod;
         assign r_prod = $signed({1'b0, req_data.row_index}) * radius_step_ff;
         assign h_prod = $signed({1'b0, req_data.row_index}) * height_step_ff;
         // Capture the vertex, form radius and height, seed the u and v remainders
         always_comb begin
            pipe_in[j]        = '0;
            pipe_in[j].row    = req_data.row_index;
            pipe_in[j].col    = req_data.column_index;
            pipe_in[j].radius = r_prod + $signed({11'd0, base_radius_ff});
            pipe_in[j].pos_y  = sat24(68'(h_prod));
            pipe_in[j].u_r    = (req_data.column_index < cols_eff) ?
                                req_data.column_index : 9'd0;
            pipe_in[j].v_r    = (req_data.row_index < rows_eff) ?
                                req_data.row_index : 9'd0;
         end
      end else if (j < FRAC_FIRST) begin : g_mod
         logic [9:0] r2;
         assign r2 = {pipe_ff[j-1].rem, pipe_ff[j-1].col[MOD_STEPS-j]};
         // One restoring step of column modulo count
         always_comb begin
            pipe_in[j] = pipe_ff[j-1];
            if (r2 >= {1'b0, cols_eff}) begin
               pipe_in[j].rem = 9'(r2 - {1'b0, cols_eff});
            end else begin
               pipe_in[j].rem = r2[8:0];
            end
         end
      end else if (j < FIN_STG) begin : g_frac
         logic [9:0] t2;
         logic [9:0] u2;
         logic [9:0] v2;
         logic       tb;
         logic       ub;
         logic       vb;
         assign t2 = (j == FRAC_FIRST) ? {pipe_ff[j-1].rem, 1'b0}
                                       : {pipe_ff[j-1].th_r, 1'b0};
         assign u2 = {pipe_ff[j-1].u_r, 1'b0};
         assign v2 = {pipe_ff[j-1].v_r, 1'b0};
         assign tb = (t2 >= {1'b0, cols_eff});
         assign ub = (u2 >= {1'b0, cols_eff});
         assign vb = (v2 >= {1'b0, rows_eff});
         // One quotient bit of phase, plus one of u and v until each quotient is full
         always_comb begin
            pipe_in[j]      = pipe_ff[j-1];
            pipe_in[j].th_r = tb ? 9'(t2 - {1'b0, cols_eff}) : t2[8:0];
            pipe_in[j].th_q = {pipe_ff[j-1].th_q[TH_BITS-2:0], tb};
            if (j - FRAC_FIRST < U_BITS) begin
               pipe_in[j].u_r = ub ? 9'(u2 - {1'b0, cols_eff}) : u2[8:0];
               pipe_in[j].u_q = {pipe_ff[j-1].u_q[U_BITS-2:0], ub};
            end
            if (j - FRAC_FIRST < V_BITS) begin
               pipe_in[j].v_r = vb ? 9'(v2 - {1'b0, rows_eff}) : v2[8:0];
               pipe_in[j].v_q = {pipe_ff[j-1].v_q[V_BITS-2:0], vb};
            end
         end
      end else if (j == FIN_STG) begin : g_fin
         logic [33:0] th_sum;
         logic [31:0] th;
         logic [18:0] u_sum;
         logic [17:0] v_sum;
         assign th_sum = {1'b0, pipe_ff[j-1].th_q} + 34'd1;
         assign th     = (cols_eff == 9'd0) ? 32'd0 : th_sum[32:1];
         assign u_sum  = {1'b0, pipe_ff[j-1].u_q} + 19'd1;
         assign v_sum  = {1'b0, pipe_ff[j-1].v_q} + 18'd1;
         // Round the quotients, clamp UV, seed the rotation
         always_comb begin
            pipe_in[j]      = pipe_ff[j-1];
            pipe_in[j].cx   = CORDIC_GAIN;
            pipe_in[j].cy   = '0;
            pipe_in[j].cz   = $signed({3'd0, th[29:0]});
            pipe_in[j].quad = th[31:30];
            if (cols_eff == 9'd0) begin
               pipe_in[j].tex_u = '0;
            end else if (pipe_ff[j-1].col >= cols_eff) begin
               pipe_in[j].tex_u = U_FULL;
            end else begin
               pipe_in[j].tex_u = u_sum[18:1];
            end
            if (rows_eff == 9'd0) begin
               pipe_in[j].tex_v = '0;
            end else if (pipe_ff[j-1].row >= rows_eff) begin
               pipe_in[j].tex_v = V_FULL;
            end else begin
               pipe_in[j].tex_v = v_sum[17:1];
            end
         end
      end else if (j < QUAD_STG) begin : g_cordic
         logic signed [32:0] dx;
         logic signed [32:0] dy;
         logic signed [32:0] at;
         assign dx = pipe_ff[j-1].cy >>> (j - CORDIC_FIRST);
         assign dy = pipe_ff[j-1].cx >>> (j - CORDIC_FIRST);
         assign at = $signed({1'b0, atan_val(j - CORDIC_FIRST)});
         // Rotate toward zero residual angle
         always_comb begin
            pipe_in[j] = pipe_ff[j-1];
            if (!pipe_ff[j-1].cz[32]) begin
               pipe_in[j].cx = pipe_ff[j-1].cx - dx;
               pipe_in[j].cy = pipe_ff[j-1].cy + dy;
               pipe_in[j].cz = pipe_ff[j-1].cz - at;
            end else begin
               pipe_in[j].cx = pipe_ff[j-1].cx + dx;
               pipe_in[j].cy = pipe_ff[j-1].cy - dy;
               pipe_in[j].cz = pipe_ff[j-1].cz + at;
            end
         end
      end else if (j == QUAD_STG) begin : g_quad
         // Fold in the quadrant: ax is minus sine, az is cosine
         always_comb begin
            pipe_in[j] = pipe_ff[j-1];
            case (pipe_ff[j-1].quad)
               2'd0: begin
                  pipe_in[j].ax = -pipe_ff[j-1].cy;
                  pipe_in[j].az = pipe_ff[j-1].cx;
               end
               2'd1: begin
                  pipe_in[j].ax = -pipe_ff[j-1].cx;
                  pipe_in[j].az = -pipe_ff[j-1].cy;
               end
               2'd2: begin
                  pipe_in[j].ax = pipe_ff[j-1].cy;
                  pipe_in[j].az = -pipe_ff[j-1].cx;
               end
               default: begin
                  pipe_in[j].ax = pipe_ff[j-1].cx;
                  pipe_in[j].az = pipe_ff[j-1].cy;
               end
            endcase
         end
      end else if (j == MULT_STG) begin : g_mult
         logic signed [17:0] rlo;
         logic signed [16:0] rhi;
         assign rlo = $signed({1'b0, pipe_ff[j-1].radius[16:0]});
         assign rhi = pipe_ff[j-1].radius[33:17];
         // Split the radius into two partial products per axis
         always_comb begin
            pipe_in[j]     = pipe_ff[j-1];
            pipe_in[j].pxl = pipe_ff[j-1].ax * rlo;
            pipe_in[j].pxh = pipe_ff[j-1].ax * rhi;
            pipe_in[j].pzl = pipe_ff[j-1].az * rlo;
            pipe_in[j].pzh = pipe_ff[j-1].az * rhi;
         end
      end else if (j == SUM_STG) begin : g_sum
         // Combine partial products and add the rounding half
         always_comb begin
            pipe_in[j]    = pipe_ff[j-1];
            pipe_in[j].sx = (68'(pipe_ff[j-1].pxh) <<< 17) + 68'(pipe_ff[j-1].pxl)
                            + 68'sd536870912;
            pipe_in[j].sz = (68'(pipe_ff[j-1].pzh) <<< 17) + 68'(pipe_ff[j-1].pzl)
                            + 68'sd536870912;
         end
      end else begin : g_out
         // Drop the fraction and saturate
         always_comb begin
            pipe_in[j]    = pipe_ff[j-1];
            pipe_in[j].ox = sat24(pipe_ff[j-1].sx >>> 30);
            pipe_in[j].oz = sat24(pipe_ff[j-1].sz >>> 30);
         end
      end
   end

   // Advance valid bits and payload together
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STG-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_STG; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_valid      = vld_ff[OUT_STG];
   assign rsp_data.pos_x = pipe_ff[OUT_STG].ox;
   assign rsp_data.pos_y = pipe_ff[OUT_STG].pos_y;
   assign rsp_data.pos_z = pipe_ff[OUT_STG].oz;
   assign rsp_data.tex_u = pipe_ff[OUT_STG].tex_u;
   assign rsp_data.tex_v = pipe_ff[OUT_STG].tex_v;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");
   a_entry: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted vertex missing from first stage");
   a_u_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.tex_u <= U_FULL))
      else $error("tex_u above 2.0");
   a_v_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.tex_v <= V_FULL))
      else $error("tex_v above 1.0");
`endif

endmodule
